// ===== hdl/type_length_message_deframer_macros.svh =====
// Assertion macros shared by the deframer modules.
`ifndef TYPE_LENGTH_MESSAGE_DEFRAMER_MACROS_SVH
`define TYPE_LENGTH_MESSAGE_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent holds -> consequent holds in the same cycle
`define TLMD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlmd check failed");

// antecedent holds -> consequent holds in the next cycle
`define TLMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlmd check failed");

`else

`define TLMD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TLMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/tlmd_pkg.sv =====
package tlmd_pkg;

	localparam logic [31:0] MAX_LEN_RESET = 32'd10485760;

	typedef enum logic [2:0] {
		EV_PAYLOAD      = 3'd0,
		EV_FRAME_OK     = 3'd1,
		EV_UNKNOWN_TYPE = 3'd2,
		EV_TOO_LONG     = 3'd3,
		EV_DISC_MID     = 3'd4,
		EV_DISC_IDLE    = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		TC_LO      = 3'd0,
		TC_SS      = 3'd1,
		TC_SU      = 3'd2,
		TC_PC      = 3'd3,
		TC_PD      = 3'd4,
		TC_PB      = 3'd5,
		TC_UNKNOWN = 3'd6
	} type_code_t;

	// ASCII type words, first byte in the upper half
	localparam logic [15:0] TYPE_LO = 16'h4C4F;
	localparam logic [15:0] TYPE_SS = 16'h5353;
	localparam logic [15:0] TYPE_SU = 16'h5355;
	localparam logic [15:0] TYPE_PC = 16'h5043;
	localparam logic [15:0] TYPE_PD = 16'h5044;
	localparam logic [15:0] TYPE_PB = 16'h5042;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  data;
		type_code_t  code;
		logic [15:0] raw_type;
		logic [31:0] frame_length;
		logic        last;
	} result_t;

	// up to two results per request, written to the queue together
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

	localparam int QDEPTH = 3;
	typedef logic [1:0] qptr_t;

	function automatic qptr_t qptr_inc(input qptr_t p);
		qptr_t r;
		if (p == qptr_t'(QDEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + qptr_t'(1);
		end
		return r;
	endfunction

	function automatic type_code_t classify(input logic [15:0] t);
		type_code_t c;
		unique case (t)
			TYPE_LO: c = TC_LO;
			TYPE_SS: c = TC_SS;
			TYPE_SU: c = TC_SU;
			TYPE_PC: c = TC_PC;
			TYPE_PD: c = TC_PD;
			TYPE_PB: c = TC_PB;
			default: c = TC_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/type_length_message_deframer.sv =====
// Type/length/value deframer: takes one received byte per request (or a
// disconnect marker), collects the 2-byte type and 4-byte big-endian length,
// passes payload bytes through, then emits a status (frame ok with type code,
// or unknown type). A length above max_payload_length (reset 10485760) gives
// too-long and all bytes are dropped until a disconnect. A byte is taken every
// clock while in_stall is low; its results are registered in the result queue
// when it is accepted. The last payload byte of a frame gives two results, so
// the output side takes two results there. A three-entry result queue sets the
// input stall: in_stall is high while two or more results wait (not on out_stall).
module type_length_message_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        disconnect,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic [2:0]  type_code,
	output logic [15:0] raw_type,
	output logic [31:0] frame_length,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	tlmd_pkg::push_t   push;
	tlmd_pkg::result_t head;
	logic              fire;
	logic              pop;
	logic [1:0]        level;

	assign in_stall = (level > 2'd1);
	assign fire     = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	tlmd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.rx_byte     (rx_byte),
		.disconnect  (disconnect),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push)
	);

	tlmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.not_empty (out_valid),
		.head      (head),
		.level     (level)
	);

	assign event_res    = head.ev;
	assign data_byte    = head.data;
	assign type_code    = head.code;
	assign raw_type     = head.raw_type;
	assign frame_length = head.frame_length;
	assign last         = head.last;

endmodule

// ===== hdl/tlmd_queue.sv =====
`include "type_length_message_deframer_macros.svh"

module tlmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  tlmd_pkg::push_t   push,
	input  logic              pop,
	output logic              not_empty,
	output tlmd_pkg::result_t head,
	output logic [1:0]        level
);

	tlmd_pkg::result_t mem_q [tlmd_pkg::QDEPTH];
	tlmd_pkg::qptr_t   rd_ptr_q;
	tlmd_pkg::qptr_t   wr_ptr_q;
	tlmd_pkg::qptr_t   wr_ptr_1;
	logic [1:0]        count_q;

	assign wr_ptr_1  = tlmd_pkg::qptr_inc(wr_ptr_q);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= tlmd_pkg::qptr_inc(rd_ptr_q);
			end
			if (push.cnt == 2'd1) begin
				wr_ptr_q <= wr_ptr_1;
			end else if (push.cnt == 2'd2) begin
				wr_ptr_q <= tlmd_pkg::qptr_inc(wr_ptr_1);
			end
			count_q <= 2'(count_q + push.cnt - {1'b0, pop});
		end
	end

	// a push needs room for two results
	`TLMD_ASSERT_IMPL(a_push_room, clk, arst_n, push.cnt != 2'd0, count_q <= 2'd1)
	`TLMD_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, count_q != 2'd0)

endmodule

// ===== hdl/tlmd_parser.sv =====
`include "type_length_message_deframer_macros.svh"

module tlmd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      rx_byte,
	input  logic            disconnect,
	input  logic            cfg_wr_en,
	input  logic [31:0]     cfg_wr_data,
	output tlmd_pkg::push_t push
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	phase_t      phase_q,  phase_d;
	logic [2:0]  hidx_q,   hidx_d;
	logic [15:0] type_q,   type_d;
	logic [31:0] len_q,    len_d;
	logic [31:0] rem_q,    rem_d;
	logic [31:0] max_len_q;

	tlmd_pkg::result_t status;
	tlmd_pkg::type_code_t code;

	assign code = tlmd_pkg::classify(type_q);

	always_comb begin
		status              = '0;
		status.ev           = (code == tlmd_pkg::TC_UNKNOWN) ?
		                      tlmd_pkg::EV_UNKNOWN_TYPE : tlmd_pkg::EV_FRAME_OK;
		status.code         = code;
		status.raw_type     = type_q;
		status.frame_length = len_q;
		status.last         = 1'b1;
	end

	always_comb begin
		phase_d = phase_q;
		hidx_d  = hidx_q;
		type_d  = type_q;
		len_d   = len_q;
		rem_d   = rem_q;
		push    = '0;
		if (fire) begin
			if (disconnect) begin
				push.cnt     = 2'd1;
				push.r0.ev   = (phase_q == PH_HEADER && hidx_q == 3'd0) ?
				               tlmd_pkg::EV_DISC_IDLE : tlmd_pkg::EV_DISC_MID;
				push.r0.last = 1'b1;
				phase_d      = PH_HEADER;
				hidx_d       = '0;
				type_d       = '0;
				len_d        = '0;
				rem_d        = '0;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (hidx_q < 3'd2) begin
							type_d = {type_q[7:0], rx_byte};
						end else begin
							len_d = {len_q[23:0], rx_byte};
						end
						if (hidx_q == 3'd5) begin
							hidx_d = '0;
							if (len_d > max_len_q) begin
								phase_d                = PH_DISCARD;
								push.cnt               = 2'd1;
								push.r0.ev             = tlmd_pkg::EV_TOO_LONG;
								push.r0.raw_type       = type_q;
								push.r0.frame_length   = len_d;
								push.r0.last           = 1'b1;
							end else if (len_d == 32'd0) begin
								// empty frame: status straight after the header
								push.cnt             = 2'd1;
								push.r0              = status;
								push.r0.frame_length = len_d;
								type_d               = '0;
							end else begin
								phase_d = PH_PAYLOAD;
								rem_d   = len_d;
							end
						end else begin
							hidx_d = hidx_q + 3'd1;
						end
					end
					PH_PAYLOAD: begin
						rem_d                = rem_q - 32'd1;
						push.r0.ev           = tlmd_pkg::EV_PAYLOAD;
						push.r0.data         = rx_byte;
						push.r0.raw_type     = type_q;
						push.r0.frame_length = len_q;
						if (rem_q != 32'd1) begin
							push.cnt     = 2'd1;
							push.r0.last = 1'b1;
						end else begin
							push.cnt     = 2'd2;
							push.r0.last = 1'b0;
							push.r1      = status;
							phase_d      = PH_HEADER;
							type_d       = '0;
							len_d        = '0;
						end
					end
					PH_DISCARD: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hidx_q    <= '0;
			type_q    <= '0;
			len_q     <= '0;
			rem_q     <= '0;
			max_len_q <= tlmd_pkg::MAX_LEN_RESET;
		end else begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			type_q  <= type_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
		end
	end

	`TLMD_ASSERT_IMPL(a_rem_live, clk, arst_n, phase_q == PH_PAYLOAD, rem_q != 32'd0)
	`TLMD_ASSERT_IMPL(a_hidx_hdr, clk, arst_n, phase_q != PH_HEADER, hidx_q == 3'd0)
	`TLMD_ASSERT_NEXT(a_disc_clear, clk, arst_n, fire && disconnect,
		phase_q == PH_HEADER && hidx_q == 3'd0)

endmodule
